@@ hdl/rgb_remote_pulse_decoder_core_macros.svh @@
// Assertion macros for the pulse decoder checker file
`ifndef RGB_REMOTE_PULSE_DECODER_CORE_MACROS_SVH
`define RGB_REMOTE_PULSE_DECODER_CORE_MACROS_SVH

// Clocked assertion, ignored while reset is high
`define RGBPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define RGBPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rgbpd_pkg.sv @@
// Shared types and constants for the RGB remote pulse decoder
`timescale 1ns / 1ps

package rgbpd_pkg;

   // Field widths
   localparam int WIDTH_W  = 16;
   localparam int COUNT_W  = 8;
   localparam int STATUS_W = 3;
   localparam int ID_W     = 16;
   localparam int CMD_W    = 8;
   localparam int BITCNT_W = 6;
   localparam int SHIFT_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // Data bits in a frame before the checksum bit
   localparam logic [BITCNT_W-1:0] DATA_BITS = 6'd32;
   // Byte 1 of the received word must be all ones
   localparam logic [SHIFT_W-1:0] CONST_MASK = 32'h0000_FF00;

   // Status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_COUNT     = 3'd1;
   localparam status_type ST_NO_START  = 3'd2;
   localparam status_type ST_ORDER     = 3'd3;
   localparam status_type ST_NO_CHECK  = 3'd4;
   localparam status_type ST_STOP      = 3'd5;
   localparam status_type ST_CONST     = 3'd6;
   localparam status_type ST_PARITY    = 3'd7;

   // Register indexes
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type REG_MIN_COUNT   = 3'd0;
   localparam csr_index_type REG_MAX_COUNT   = 3'd1;
   localparam csr_index_type REG_START_LOW   = 3'd2;
   localparam csr_index_type REG_START_HIGH  = 3'd3;
   localparam csr_index_type REG_ONE_LOW     = 3'd4;
   localparam csr_index_type REG_ONE_HIGH    = 3'd5;

   // Register reset values
   localparam logic [COUNT_W-1:0] MIN_COUNT_RST  = 8'd134;
   localparam logic [COUNT_W-1:0] MAX_COUNT_RST  = 8'd164;
   localparam logic [WIDTH_W-1:0] START_LOW_RST  = 16'd1200;
   localparam logic [WIDTH_W-1:0] START_HIGH_RST = 16'd1500;
   localparam logic [WIDTH_W-1:0] ONE_LOW_RST    = 16'd750;
   localparam logic [WIDTH_W-1:0] ONE_HIGH_RST   = 16'd1000;

endpackage

@@ hdl/rgb_remote_pulse_decoder_core.sv @@
// RGB remote pulse decoder: frame decode from a stream of pulse widths
// Accepted requests are registered in the input stage, responses in the output stage.
// Throughput: one request per cycle; a last request waits while a response is stalled.
// Only a request marked last produces a response; others update frame state only.
// Synchronous reset clears frame state and both stages and restores register defaults.
`timescale 1ns / 1ps

module rgb_remote_pulse_decoder_core #(
   parameter int unsigned START_SEARCH_LIMIT = 100
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] pulse_width
   input  logic        req_tlast,   // last_pulse
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] status, [18:3] remote_id, [26:19] command_code
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [rgbpd_pkg::COUNT_W-1:0] SEARCH_LIMIT =
      rgbpd_pkg::COUNT_W'(START_SEARCH_LIMIT);

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_BITS,
      PH_DONE
   } phase_type;

   // Configuration registers
   logic [rgbpd_pkg::COUNT_W-1:0] min_count_ff;
   logic [rgbpd_pkg::COUNT_W-1:0] max_count_ff;
   logic [rgbpd_pkg::WIDTH_W-1:0] start_low_ff;
   logic [rgbpd_pkg::WIDTH_W-1:0] start_high_ff;
   logic [rgbpd_pkg::WIDTH_W-1:0] one_low_ff;
   logic [rgbpd_pkg::WIDTH_W-1:0] one_high_ff;

   // Input stage
   logic                          item_valid_ff, item_valid_in;
   logic [rgbpd_pkg::WIDTH_W-1:0] item_width_ff;
   logic                          item_last_ff;

   // Frame state
   phase_type                      phase_ff, phase_in;
   logic [rgbpd_pkg::COUNT_W-1:0]  pulse_count_ff, pulse_count_in;
   logic [rgbpd_pkg::BITCNT_W-1:0] bit_count_ff, bit_count_in;
   logic [rgbpd_pkg::SHIFT_W-1:0]  shift_bits_ff, shift_bits_in;
   logic                           parity_ff, parity_in;
   logic                           half_zero_ff, half_zero_in;
   logic                           check_bit_ff, check_bit_in;
   rgbpd_pkg::status_type          error_ff, error_in;
   logic [rgbpd_pkg::WIDTH_W-1:0]  dly0_ff, dly0_in;
   logic [rgbpd_pkg::WIDTH_W-1:0]  dly1_ff, dly1_in;
   logic [rgbpd_pkg::WIDTH_W-1:0]  dly2_ff, dly2_in;

   // Output stage
   logic                          rsp_valid_ff, rsp_valid_in;
   rgbpd_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [rgbpd_pkg::ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [rgbpd_pkg::CMD_W-1:0]   rsp_cmd_ff, rsp_cmd_in;

   // Handshake control
   logic slot_free;
   logic advance;
   logic load_rsp;

   // Decode scratch
   logic [rgbpd_pkg::COUNT_W-1:0] pulse_idx;
   logic                          is_long;
   logic                          finish;
   rgbpd_pkg::status_type         status;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && (!item_last_ff || slot_free);
   assign load_rsp   = advance && item_last_ff;
   assign req_tready = !reset && (!item_valid_ff || advance);

   assign item_valid_in = (req_tvalid && req_tready) || (item_valid_ff && !advance);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_cmd_ff, rsp_id_ff, rsp_status_ff};

   assign is_long = (dly2_ff > one_low_ff) && (dly2_ff < one_high_ff);

   // Per-pulse frame update and end-of-frame result
   always_comb begin
      phase_in       = phase_ff;
      pulse_count_in = pulse_count_ff;
      bit_count_in   = bit_count_ff;
      shift_bits_in  = shift_bits_ff;
      parity_in      = parity_ff;
      half_zero_in   = half_zero_ff;
      check_bit_in   = check_bit_ff;
      error_in       = error_ff;
      dly0_in        = dly0_ff;
      dly1_in        = dly1_ff;
      dly2_in        = dly2_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_cmd_in     = rsp_cmd_ff;
      finish         = 1'b0;
      status         = rgbpd_pkg::ST_OK;
      pulse_idx      = '0;

      if (advance) begin
         // Saturating pulse count
         if (pulse_count_ff != {rgbpd_pkg::COUNT_W{1'b1}}) begin
            pulse_count_in = pulse_count_ff + 8'd1;
         end
         pulse_idx = pulse_count_in - 8'd3;

         // Decode the pulse three behind the newest one
         if (pulse_count_in >= 8'd4) begin
            case (phase_ff)
               PH_SEARCH: begin
                  if (dly2_ff > start_low_ff && dly2_ff < start_high_ff) begin
                     phase_in = PH_BITS;
                  end else if (pulse_idx > SEARCH_LIMIT) begin
                     error_in = rgbpd_pkg::ST_NO_START;
                     phase_in = PH_DONE;
                  end
               end
               PH_BITS: begin
                  if (is_long) begin
                     if (half_zero_ff) begin
                        error_in = rgbpd_pkg::ST_ORDER;
                        phase_in = PH_DONE;
                     end else if (bit_count_ff < rgbpd_pkg::DATA_BITS) begin
                        shift_bits_in = {shift_bits_ff[rgbpd_pkg::SHIFT_W-2:0], 1'b1};
                        bit_count_in  = bit_count_ff + 6'd1;
                     end else begin
                        check_bit_in = 1'b1;
                        finish       = 1'b1;
                     end
                  end else if (!half_zero_ff) begin
                     half_zero_in = 1'b1;
                  end else begin
                     half_zero_in = 1'b0;
                     if (bit_count_ff < rgbpd_pkg::DATA_BITS) begin
                        shift_bits_in = {shift_bits_ff[rgbpd_pkg::SHIFT_W-2:0], 1'b0};
                        parity_in     = !parity_ff;
                        bit_count_in  = bit_count_ff + 6'd1;
                     end else begin
                        check_bit_in = 1'b0;
                        finish       = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase

            // Checksum bit taken: check stop pulse, constant byte, parity
            if (finish) begin
               phase_in = PH_DONE;
               if (dly0_ff < start_low_ff || dly0_ff > start_high_ff) begin
                  error_in = rgbpd_pkg::ST_STOP;
               end else if ((shift_bits_ff & rgbpd_pkg::CONST_MASK) !=
                            rgbpd_pkg::CONST_MASK) begin
                  error_in = rgbpd_pkg::ST_CONST;
               end else if (parity_ff != check_bit_in) begin
                  error_in = rgbpd_pkg::ST_PARITY;
               end else begin
                  error_in = rgbpd_pkg::ST_OK;
               end
            end
         end

         // Advance the delay line
         dly2_in = dly1_ff;
         dly1_in = dly0_ff;
         dly0_in = item_width_ff;

         // Last pulse: form the response and clear the frame
         if (item_last_ff) begin
            if (pulse_count_in < min_count_ff || pulse_count_in > max_count_ff) begin
               status = rgbpd_pkg::ST_COUNT;
            end else if (phase_in == PH_SEARCH) begin
               status = rgbpd_pkg::ST_NO_START;
            end else if (phase_in == PH_BITS) begin
               status = rgbpd_pkg::ST_NO_CHECK;
            end else begin
               status = error_in;
            end
            rsp_status_in = status;
            if (status == rgbpd_pkg::ST_OK) begin
               rsp_id_in  = shift_bits_in[rgbpd_pkg::SHIFT_W-1:rgbpd_pkg::SHIFT_W-rgbpd_pkg::ID_W];
               rsp_cmd_in = shift_bits_in[rgbpd_pkg::CMD_W-1:0];
            end else begin
               rsp_id_in  = '0;
               rsp_cmd_in = '0;
            end
            phase_in       = PH_SEARCH;
            pulse_count_in = '0;
            bit_count_in   = '0;
            shift_bits_in  = '0;
            parity_in      = 1'b0;
            half_zero_in   = 1'b0;
            check_bit_in   = 1'b0;
            error_in       = rgbpd_pkg::ST_OK;
            dly0_in        = '0;
            dly1_in        = '0;
            dly2_in        = '0;
         end
      end
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);

   // Hold state, configuration and both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff   <= rgbpd_pkg::MIN_COUNT_RST;
         max_count_ff   <= rgbpd_pkg::MAX_COUNT_RST;
         start_low_ff   <= rgbpd_pkg::START_LOW_RST;
         start_high_ff  <= rgbpd_pkg::START_HIGH_RST;
         one_low_ff     <= rgbpd_pkg::ONE_LOW_RST;
         one_high_ff    <= rgbpd_pkg::ONE_HIGH_RST;
         item_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_SEARCH;
         pulse_count_ff <= '0;
         bit_count_ff   <= '0;
         shift_bits_ff  <= '0;
         parity_ff      <= 1'b0;
         half_zero_ff   <= 1'b0;
         check_bit_ff   <= 1'b0;
         error_ff       <= rgbpd_pkg::ST_OK;
         dly0_ff        <= '0;
         dly1_ff        <= '0;
         dly2_ff        <= '0;
      end else begin
         // Register writes; unknown indexes drop
         if (csr_we) begin
            case (csr_index)
               rgbpd_pkg::REG_MIN_COUNT:  min_count_ff  <= csr_wdata[rgbpd_pkg::COUNT_W-1:0];
               rgbpd_pkg::REG_MAX_COUNT:  max_count_ff  <= csr_wdata[rgbpd_pkg::COUNT_W-1:0];
               rgbpd_pkg::REG_START_LOW:  start_low_ff  <= csr_wdata;
               rgbpd_pkg::REG_START_HIGH: start_high_ff <= csr_wdata;
               rgbpd_pkg::REG_ONE_LOW:    one_low_ff    <= csr_wdata;
               rgbpd_pkg::REG_ONE_HIGH:   one_high_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         item_valid_ff  <= item_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         phase_ff       <= phase_in;
         pulse_count_ff <= pulse_count_in;
         bit_count_ff   <= bit_count_in;
         shift_bits_ff  <= shift_bits_in;
         parity_ff      <= parity_in;
         half_zero_ff   <= half_zero_in;
         check_bit_ff   <= check_bit_in;
         error_ff       <= error_in;
         dly0_ff        <= dly0_in;
         dly1_ff        <= dly1_in;
         dly2_ff        <= dly2_in;
      end

      // Capture an accepted request
      if (req_tvalid && req_tready) begin
         item_width_ff <= req_tdata;
         item_last_ff  <= req_tlast;
      end

      // Load the response payload
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_cmd_ff    <= rsp_cmd_in;
      end
   end

endmodule

@@ hdl/rgbpd_checker.sv @@
// Port-level assertion checker for the pulse decoder and its bind
`timescale 1ns / 1ps
`include "rgb_remote_pulse_decoder_core_macros.svh"

module rgbpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled response holds
   `RGBPD_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)), "response changed while stalled")

   // A failed frame carries no id or command
   `RGBPD_ASSERT(a_fail_clear, clock, reset, (rsp_tvalid && rsp_tdata[2:0] != rgbpd_pkg::ST_OK |-> rsp_tdata[26:3] == 24'd0), "failed frame carries payload")

   // A new response follows an accepted last request
   `RGBPD_ASSERT(a_rsp_source, clock, reset, ($rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2)), "response without last request")

   // Reset empties the output stage
   `RGBPD_ASSERT_ALWAYS(a_reset_empty, clock, (reset |=> !rsp_tvalid), "response valid after reset")

endmodule

bind rgb_remote_pulse_decoder_core rgbpd_checker u_rgbpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
